@@ sv/bsss_pkg.sv @@
// shared constants, types and helpers of the bounded sorted series store
// used by every module of the block but bsss_ram; depends on nothing
`default_nettype none

package bsss_pkg;

  localparam int NUM_SERIES = 8;
  localparam int DEPTH      = 16;

  localparam int KEY_W  = 64;
  localparam int TIME_W = 64;
  localparam int DATA_W = 64;
  localparam int MAXP_W = 5;

  localparam int PT_DEPTH = NUM_SERIES * DEPTH;
  localparam int WORD_W   = TIME_W + DATA_W;
  localparam int SLOT_W   = (NUM_SERIES > 1) ? $clog2(NUM_SERIES) : 1;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int K_W      = $clog2(DEPTH + 2);
  localparam int ADDR_W   = $clog2(PT_DEPTH);

  localparam int IN_TDATA_W  = KEY_W + TIME_W + DATA_W + 2 * TIME_W;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = WORD_W;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic {
    OP_PUT   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_e;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
    logic              free_ok;
    logic [SLOT_W-1:0] free_slot;
  } lkp_t;

  typedef struct packed {
    logic              claim;
    logic              cnt_we;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  cnt;
  } upd_t;

  function automatic logic [ADDR_W-1:0] pt_addr(input logic [SLOT_W-1:0] slot,
                                                 input logic [IDX_W-1:0] idx);
    pt_addr = ADDR_W'(ADDR_W'(slot) * ADDR_W'(DEPTH)) + ADDR_W'(idx);
  endfunction

endpackage

`default_nettype wire

@@ sv/bsss_ram.sv @@
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module bsss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/bsss_slot_table.sv @@
// series slot table: used flags, keys and point counts with parallel key lookup
// depends on bsss_pkg
`default_nettype none

module bsss_slot_table (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [bsss_pkg::KEY_W-1:0]  key_i,
  input  wire bsss_pkg::upd_t              upd_i,
  output bsss_pkg::lkp_t                   lkp_o
);

  logic [bsss_pkg::NUM_SERIES-1:0] used_q;
  logic [bsss_pkg::KEY_W-1:0]      key_q [bsss_pkg::NUM_SERIES];
  logic [bsss_pkg::CNT_W-1:0]      cnt_q [bsss_pkg::NUM_SERIES];

  // lowest matching slot and lowest free slot
  always_comb begin
    lkp_o = '0;
    for (int s = bsss_pkg::NUM_SERIES - 1; s >= 0; s--) begin
      if (used_q[s] && key_q[s] == key_i) begin
        lkp_o.hit  = 1'b1;
        lkp_o.slot = bsss_pkg::SLOT_W'(s);
      end
      if (!used_q[s]) begin
        lkp_o.free_ok   = 1'b1;
        lkp_o.free_slot = bsss_pkg::SLOT_W'(s);
      end
    end
    lkp_o.count = cnt_q[lkp_o.slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      for (int s = 0; s < bsss_pkg::NUM_SERIES; s++) begin
        cnt_q[s] <= '0;
      end
    end else begin
      if (upd_i.claim) begin
        used_q[upd_i.slot] <= 1'b1;
        cnt_q[upd_i.slot]  <= '0;
      end
      if (upd_i.cnt_we) begin
        cnt_q[upd_i.slot] <= upd_i.cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.claim) begin
      key_q[upd_i.slot] <= key_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/bsss_seq.sv @@
// sequencer: lookup, sorted insert with trim, range scan and output register
// depends on bsss_pkg; drives the point ram and the slot table
`default_nettype none

module bsss_seq (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [bsss_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input  wire logic [bsss_pkg::IN_TUSER_W-1:0]   s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic [bsss_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o,
  output logic [bsss_pkg::OUT_TUSER_W-1:0]       m_axis_tuser_o,
  output logic                                   m_axis_tlast_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bsss_pkg::MAXP_W-1:0]       cfg_data_i,
  output logic [bsss_pkg::KEY_W-1:0]             key_o,
  input  wire bsss_pkg::lkp_t                    lkp_i,
  output bsss_pkg::upd_t                         upd_o,
  output logic                                   ram_we_o,
  output logic [bsss_pkg::ADDR_W-1:0]            ram_waddr_o,
  output logic [bsss_pkg::WORD_W-1:0]            ram_wdata_o,
  output logic                                   ram_re_o,
  output logic [bsss_pkg::ADDR_W-1:0]            ram_raddr_o,
  input  wire logic [bsss_pkg::WORD_W-1:0]       ram_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_PUT,
    ST_QRY,
    ST_EMIT
  } state_e;

  localparam int TW = bsss_pkg::TIME_W;
  localparam int DW = bsss_pkg::DATA_W;
  localparam int KW = bsss_pkg::K_W;

  state_e                         state_q;
  bsss_pkg::op_e                  op_q;
  bsss_pkg::status_e              stat_q;
  logic [bsss_pkg::KEY_W-1:0]     key_q;
  logic [TW-1:0]                  time_q;
  logic [DW-1:0]                  data_q;
  logic [TW-1:0]                  lo_q;
  logic [TW-1:0]                  hi_q;
  logic [bsss_pkg::SLOT_W-1:0]    slot_q;
  logic [KW-1:0]                  n_q;
  logic [KW-1:0]                  drop_q;
  logic [KW-1:0]                  k_q;
  logic                           ins_q;
  logic [bsss_pkg::WORD_W-1:0]    carry_q;
  logic                           pend_v_q;
  logic [bsss_pkg::WORD_W-1:0]    pend_q;
  logic                           out_valid_q;
  logic [bsss_pkg::WORD_W-1:0]    out_word_q;
  logic [bsss_pkg::OUT_TUSER_W-1:0] out_user_q;
  logic                           out_last_q;
  logic [bsss_pkg::MAXP_W-1:0]    max_points_q;

  logic                           o_free;
  logic [TW-1:0]                  rd_time;
  logic [KW-1:0]                  k_next;
  logic [KW-1:0]                  n_lk;
  logic [KW-1:0]                  lim;
  logic [KW-1:0]                  total;
  logic [KW-1:0]                  drop_lk;
  logic [bsss_pkg::SLOT_W-1:0]    slot_lk;
  logic                           at_end;
  logic                           take_new;
  logic [bsss_pkg::WORD_W-1:0]    e_word;
  logic                           in_rng;
  logic                           q_last;
  logic                           q_stall;
  logic                           out_load;

  assign o_free  = !out_valid_q || m_axis_tready_i;
  assign rd_time = ram_rdata_i[TW-1:0];
  assign k_next  = k_q + KW'(1);

  // limit and trim count for the series found
  always_comb begin
    n_lk    = lkp_i.hit ? KW'(lkp_i.count) : '0;
    slot_lk = lkp_i.hit ? lkp_i.slot : lkp_i.free_slot;
    if (max_points_q == '0 || int'(max_points_q) > bsss_pkg::DEPTH) begin
      lim = KW'(bsss_pkg::DEPTH);
    end else begin
      lim = KW'(max_points_q);
    end
    total   = n_lk + KW'(1);
    drop_lk = (total > lim) ? total - lim : '0;
  end

  // merged insert step: old points up to the tie rule, then the new one
  always_comb begin
    at_end   = (k_q == n_q);
    take_new = !ins_q && (at_end || rd_time > time_q);
    if (ins_q) begin
      e_word = carry_q;
    end else if (take_new) begin
      e_word = {data_q, time_q};
    end else begin
      e_word = ram_rdata_i;
    end
  end

  assign in_rng   = (rd_time >= lo_q) && (rd_time <= hi_q);
  assign q_last   = (k_next == n_q);
  assign q_stall  = in_rng && pend_v_q && !o_free;
  assign out_load = ((state_q == ST_QRY) && !q_stall && in_rng && pend_v_q) ||
                    ((state_q == ST_EMIT) && o_free);

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = e_word;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    upd_o       = '0;
    unique case (state_q)
      ST_LOOKUP: begin
        if (op_q == bsss_pkg::OP_PUT) begin
          if (!lkp_i.hit && lkp_i.free_ok) begin
            upd_o.claim = 1'b1;
            upd_o.slot  = lkp_i.free_slot;
          end
        end
        if (lkp_i.hit && n_lk != '0) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = bsss_pkg::pt_addr(slot_lk, '0);
        end
      end
      ST_PUT: begin
        ram_we_o    = (k_q >= drop_q);
        ram_waddr_o = bsss_pkg::pt_addr(slot_q, bsss_pkg::IDX_W'(k_q - drop_q));
        if (k_next < n_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = bsss_pkg::pt_addr(slot_q, bsss_pkg::IDX_W'(k_next));
        end
        if (at_end) begin
          upd_o.cnt_we = 1'b1;
          upd_o.slot   = slot_q;
          upd_o.cnt    = bsss_pkg::CNT_W'(n_q + KW'(1) - drop_q);
        end
      end
      ST_QRY: begin
        if (!q_stall && !q_last) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = bsss_pkg::pt_addr(slot_q, bsss_pkg::IDX_W'(k_next));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      pend_v_q     <= 1'b0;
      ins_q        <= 1'b0;
      max_points_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        max_points_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            op_q    <= bsss_pkg::op_e'(s_axis_tuser_i[0]);
            key_q   <= s_axis_tdata_i[63:0];
            time_q  <= s_axis_tdata_i[127:64];
            data_q  <= s_axis_tdata_i[191:128];
            lo_q    <= s_axis_tdata_i[255:192];
            hi_q    <= s_axis_tdata_i[319:256];
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          slot_q   <= slot_lk;
          n_q      <= n_lk;
          drop_q   <= drop_lk;
          k_q      <= '0;
          ins_q    <= 1'b0;
          pend_v_q <= 1'b0;
          stat_q   <= (op_q == bsss_pkg::OP_PUT && !lkp_i.hit && !lkp_i.free_ok) ?
                      bsss_pkg::STATUS_FULL : bsss_pkg::STATUS_OK;
          if (op_q == bsss_pkg::OP_PUT) begin
            if (!lkp_i.hit && !lkp_i.free_ok) begin
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_PUT;
            end
          end else if (lkp_i.hit && n_lk != '0) begin
            state_q <= ST_QRY;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_PUT: begin
          if (!at_end) begin
            carry_q <= ram_rdata_i;
          end
          ins_q <= ins_q | take_new;
          k_q   <= k_next;
          if (at_end) begin
            state_q <= ST_EMIT;
          end
        end
        ST_QRY: begin
          if (!q_stall) begin
            if (in_rng) begin
              if (pend_v_q) begin
                out_word_q  <= pend_q;
                out_user_q  <= {1'b1, 1'(bsss_pkg::STATUS_OK)};
                out_last_q  <= 1'b0;
              end
              pend_q   <= ram_rdata_i;
              pend_v_q <= 1'b1;
            end
            k_q <= k_next;
            if (q_last) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (o_free) begin
            out_word_q  <= pend_v_q ? pend_q : '0;
            out_user_q  <= {pend_v_q, 1'(stat_q)};
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_word_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;
  assign cfg_ready_o     = 1'b1;
  assign key_o           = key_q;

endmodule

`default_nettype wire

@@ sv/bounded_sorted_series_store_core.sv @@
// top level of the bounded sorted series store: sequencer, slot table, point ram
// depends on bsss_pkg, bsss_ram, bsss_slot_table and bsss_seq
//
// usage
//   s_axis carries one put or range query per transaction; m_axis returns the
//   results of each, the final one marked by tlast. cfg writes max_points; the
//   user must write it only while no transaction is in flight (not enforced).
//   a put answers with one acknowledgement (tuser status 0) or, when the key is
//   new and all series slots are taken, with status 1 and no change.
//   a query answers with one result per stored point in range, in time order,
//   or with a single empty result (has_point 0).
// timing
//   items are processed one at a time. puts and queries both walk the series
//   through the point ram, one stored point per cycle on its single read port
//   (a query pauses while the receiver stalls), the put writing the merged
//   list back through the write port in the same pass.
// reset and stalls
//   reset empties the slot table and clears max_points (limit DEPTH); point
//   storage needs no clearing. the output register holds a result while the
//   receiver stalls; a query scan then pauses, and the next input is accepted
//   as soon as the final result of the current one sits in the register.
`default_nettype none

module bounded_sorted_series_store_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // series_key, point_time, point_data, range_start, range_end
  input  wire logic [bsss_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // op
  input  wire logic [bsss_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // out_time, out_data
  output logic [bsss_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // status, has_point
  output logic [bsss_pkg::OUT_TUSER_W-1:0]      m_axis_tuser_o,
  output logic                                  m_axis_tlast_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [bsss_pkg::MAXP_W-1:0]      cfg_data_i
);

  logic [bsss_pkg::KEY_W-1:0]  lkp_key;
  bsss_pkg::lkp_t              lkp;
  bsss_pkg::upd_t              upd;
  logic                        ram_we;
  logic [bsss_pkg::ADDR_W-1:0] ram_waddr;
  logic [bsss_pkg::WORD_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [bsss_pkg::ADDR_W-1:0] ram_raddr;
  logic [bsss_pkg::WORD_W-1:0] ram_rdata;

  bsss_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .key_o           (lkp_key),
    .lkp_i           (lkp),
    .upd_o           (upd),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata)
  );

  bsss_slot_table u_slot_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (lkp_key),
    .upd_i  (upd),
    .lkp_o  (lkp)
  );

  bsss_ram #(
    .WIDTH (bsss_pkg::WORD_W),
    .DEPTH (bsss_pkg::PT_DEPTH)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while an item is in flight");

  // no ram traffic while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !ram_we && !ram_re)
    else $error("point ram access while idle");

  // write-back never hits the entry being read ahead
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("point ram read and write collide");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> int'(ram_waddr) < bsss_pkg::PT_DEPTH)
    else $error("point ram write out of range");

endmodule

`default_nettype wire
